[rtl/rrts_pkg.sv]
package rrts_pkg;
	localparam int MAX_SEGMENTS_DEF = 16;
	localparam logic [15:0] STEP_MASK = 16'hE000;
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_SNAP = 2'd2;
endpackage

[rtl/rrts_ram.sv]
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/rrts_div.sv]
module rrts_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [16:0] dividend,
	input  logic [12:0] divisor,
	output logic        done,
	output logic [16:0] quotient
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] quo_q;
	logic [13:0] rem_q;
	logic [13:0] rem_sh;
	logic [12:0] div_q;

	assign rem_sh = {rem_q[12:0], quo_q[16]};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd16) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (rem_sh >= {1'b0, div_q}) begin
				rem_q <= rem_sh - {1'b0, div_q};
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end
endmodule

[rtl/resolution_range_table_snap_unit.sv]
// Segment table with nearest-value snapping. Clear and load beats are taken
// in the idle state; a load that flushes two held words at once also passes
// through the flush state. A snap query on an empty table answers zero; else
// it first walks all stored segments to find the table bounds (a read state
// and a bound state per segment). Unless the wanted value lies outside them,
// it then walks them again: a read and a segment state for a single value,
// and also a divide state for a range, which runs a 17-step shift-subtract
// divider. The block takes no beat until a query's answer beat has been taken.
module resolution_range_table_snap_unit #(
	parameter int MAX_SEGMENTS = rrts_pkg::MAX_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: list_word[15:0], wanted_value[31:16]
	input  logic [31:0] s_tdata,
	// tuser: command[1:0]
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: snapped_value[15:0], segment_total[20:16], table_overflowed[21], zero
	output logic [23:0] m_tdata
);
	import rrts_pkg::*;

	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int RD = 1 << AW;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FLUSH = 3'd1;
	localparam logic [2:0] ST_BRD   = 3'd2;
	localparam logic [2:0] ST_BND   = 3'd3;
	localparam logic [2:0] ST_SRD   = 3'd4;
	localparam logic [2:0] ST_SEG   = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [15:0]   first_q, step_q;
	logic [1:0]    held_q;
	logic          stopped_q, ovf_q;
	logic [CW-1:0] idx_q;
	logic [15:0]   want_q, lo_q, hi_q, best_q, cand_q;
	logic [16:0]   bdel_q;
	logic [15:0]   res_q;
	logic          cmp_q;

	logic [1:0]  cmd;
	logic [15:0] word;
	logic        lend;
	assign cmd  = s_tuser;
	assign word = s_tdata[15:0];
	assign lend = s_tlast;

	logic          we;
	logic [AW-1:0] waddr;
	logic [44:0]   wdata, rdata;
	logic [AW-1:0] raddr;
	logic [15:0]   r_from, r_to;
	logic [12:0]   r_str;
	assign r_from = rdata[15:0];
	assign r_to   = rdata[31:16];
	assign r_str  = rdata[44:32];
	assign raddr  = idx_q[AW-1:0];

	rrts_ram #(.WIDTH(45), .DEPTH(RD)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic        dstart, ddone;
	logic [16:0] dividend, quotient;
	logic [15:0] clip;
	assign clip = (want_q < r_from) ? r_from : ((want_q > r_to) ? r_to : want_q);
	assign dividend = {1'b0, clip - r_from} + {5'd0, r_str[12:1]};
	assign dstart = (state_q == ST_SEG) && (r_str != 13'd0);

	rrts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(dividend),
		.divisor(r_str), .done(ddone), .quotient(quotient)
	);

	// One segment add per cycle, driven by the load path.
	logic        add;
	logic [15:0] add_lo, add_hi;
	logic [12:0] add_str;
	logic        room;
	assign room  = count_q < CW'(MAX_SEGMENTS);
	assign we    = add && room;
	assign waddr = count_q[AW-1:0];
	assign wdata = {add_str, add_hi, add_lo};

	logic [16:0] prod;
	logic [15:0] cand_c;
	logic [16:0] delta_c;
	logic [29:0] mul;
	assign mul    = 30'(quotient) * 30'(r_str);
	assign prod   = 17'(r_from) + mul[16:0];
	assign cand_c = (mul[29:17] != '0 || prod > {1'b0, r_to}) ? r_to : prod[15:0];

	logic [15:0] seg_cand;
	assign seg_cand = (state_q == ST_DIV) ? cand_q : r_from;
	assign delta_c = (seg_cand > want_q) ? 17'(seg_cand - want_q) : 17'(want_q - seg_cand);

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	always_comb begin
		add = 1'b0;
		add_lo = first_q;
		add_hi = first_q;
		add_str = '0;
		if (state_q == ST_FLUSH) begin
			add = 1'b1;
			add_lo = step_q;
			add_hi = step_q;
		end else if (s_tvalid && s_tready && cmd == CMD_LOAD) begin
			if (!stopped_q) begin
				if (word == '0) begin
					add = held_q != 2'd0;
				end else if (held_q == 2'd1) begin
					add = ((word & STEP_MASK) != STEP_MASK) || lend;
				end else if (held_q == 2'd2) begin
					add = 1'b1;
					add_lo = (word < first_q) ? word : first_q;
					add_hi = (word < first_q) ? first_q : word;
					add_str = (step_q[12:0] == '0) ? 13'd1 : step_q[12:0];
				end else if (lend) begin
					add = 1'b1;
					add_lo = word;
					add_hi = word;
				end
			end else if (lend) begin
				add = held_q != 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			first_q   <= '0;
			step_q    <= '0;
			held_q    <= '0;
			stopped_q <= 1'b0;
			ovf_q     <= 1'b0;
			m_tvalid  <= 1'b0;
			cmp_q     <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (add) begin
				if (room) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						case (cmd)
							CMD_CLEAR: begin
								count_q   <= '0;
								held_q    <= '0;
								stopped_q <= 1'b0;
								ovf_q     <= 1'b0;
							end
							CMD_LOAD: begin
								if (!stopped_q) begin
									if (word == '0) begin
										if (held_q == 2'd2) begin
											state_q <= ST_FLUSH;
										end
										held_q    <= '0;
										stopped_q <= !lend;
									end else if (held_q == 2'd0) begin
										first_q <= word;
										held_q  <= lend ? 2'd0 : 2'd1;
									end else if (held_q == 2'd1) begin
										if ((word & STEP_MASK) == STEP_MASK) begin
											step_q <= word;
											held_q <= lend ? 2'd0 : 2'd2;
											if (lend) begin
												state_q <= ST_FLUSH;
											end
										end else begin
											first_q <= word;
											held_q  <= lend ? 2'd0 : 2'd1;
											if (lend) begin
												step_q  <= word;
												state_q <= ST_FLUSH;
											end
										end
									end else begin
										held_q <= '0;
									end
								end else if (lend) begin
									stopped_q <= 1'b0;
									held_q    <= '0;
									if (held_q == 2'd2) begin
										state_q <= ST_FLUSH;
									end
								end
							end
							CMD_SNAP: begin
								want_q <= s_tdata[31:16];
								idx_q  <= '0;
								lo_q   <= '0;
								hi_q   <= '0;
								if (count_q == '0) begin
									res_q   <= '0;
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_BRD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_FLUSH: state_q <= ST_IDLE;
				ST_BRD: state_q <= ST_BND;
				ST_BND: begin
					if (lo_q == '0 || r_from < lo_q) begin
						lo_q <= r_from;
					end
					if (r_to > hi_q) begin
						hi_q <= r_to;
					end
					if (idx_q + CW'(1) == count_q) begin
						idx_q   <= '0;
						state_q <= ST_SRD;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_SRD: begin
					if (want_q < lo_q) begin
						res_q   <= lo_q;
						state_q <= ST_OUT;
					end else if (want_q > hi_q) begin
						res_q   <= hi_q;
						state_q <= ST_OUT;
					end else begin
						if (idx_q == '0) begin
							best_q <= lo_q;
							bdel_q <= 17'h1FFFF;
						end
						state_q <= ST_SEG;
					end
				end
				ST_SEG: begin
					if (r_str != 13'd0) begin
						state_q <= ST_DIV;
						cand_q  <= '0;
					end else begin
						if (delta_c < bdel_q) begin
							bdel_q <= delta_c;
							best_q <= seg_cand;
						end
						state_q <= (idx_q + CW'(1) == count_q) ? ST_OUT : ST_SRD;
						idx_q   <= idx_q + CW'(1);
						res_q   <= (delta_c < bdel_q) ? seg_cand : best_q;
					end
				end
				ST_DIV: begin
					if (ddone) begin
						cand_q <= cand_c;
						cmp_q  <= 1'b1;
					end else if (cmp_q) begin
						cmp_q <= 1'b0;
						if (delta_c < bdel_q) begin
							bdel_q <= delta_c;
							best_q <= seg_cand;
						end
						state_q <= (idx_q + CW'(1) == count_q) ? ST_OUT : ST_SRD;
						idx_q   <= idx_q + CW'(1);
						res_q   <= (delta_c < bdel_q) ? seg_cand : best_q;
					end
				end
				ST_OUT: begin
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {2'b00, ovf_q, 5'(count_q), res_q};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata));
	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_tready);
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SEGMENTS));
endmodule

[tb/sv/rrts_checker.sv]
module rrts_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          fail_count,
	output int          pending,
	output int          snaps_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;

	localparam int NSEG = MAX_SEGMENTS_DEF;

	typedef struct packed {
		logic        overflowed;
		logic [4:0]  total;
		logic [15:0] value;
	} snap_answer_t;

	logic [15:0] seg_lo [NSEG];
	logic [15:0] seg_hi [NSEG];
	logic [12:0] seg_stride [NSEG];
	int unsigned seg_count;
	logic [15:0] held_first;
	logic [15:0] held_step;
	int unsigned held_count;
	bit stopped;
	bit overflow;
	snap_answer_t answers_due [$];

	function automatic void store_segment(logic [15:0] lo, logic [15:0] hi, logic [12:0] st);
		if (seg_count >= NSEG) begin
			overflow = 1;
			return;
		end
		seg_lo[seg_count] = lo;
		seg_hi[seg_count] = hi;
		seg_stride[seg_count] = st;
		seg_count++;
	endfunction

	function automatic void flush_held_words();
		if (held_count >= 1) store_segment(held_first, held_first, 0);
		if (held_count >= 2) store_segment(held_step, held_step, 0);
		held_count = 0;
	endfunction

	function automatic void take_list_word(logic [15:0] w);
		logic [15:0] lo;
		logic [15:0] hi;
		logic [12:0] st;
		if (stopped) return;
		if (w == 0) begin
			flush_held_words();
			stopped = 1;
		end else if (held_count == 0) begin
			held_first = w;
			held_count = 1;
		end else if (held_count == 1) begin
			if ((w & STEP_MASK) == STEP_MASK) begin
				held_step = w;
				held_count = 2;
			end else begin
				store_segment(held_first, held_first, 0);
				held_first = w;
			end
		end else begin
			st = held_step[12:0];
			if (st == 0) st = 1;
			lo = held_first;
			hi = w;
			if (hi < lo) begin
				lo = w;
				hi = held_first;
			end
			store_segment(lo, hi, st);
			held_count = 0;
		end
	endfunction

	function automatic logic [15:0] nearest_supported(logic [15:0] wanted);
		int unsigned lo, hi, best, min_gap, c, n, cand, delta, st;
		lo = 0;
		hi = 0;
		min_gap = 32'h7FFF_FFFF;
		if (seg_count == 0) return 0;
		for (int i = 0; i < seg_count; i++) begin
			if (lo == 0 || seg_lo[i] < lo) lo = seg_lo[i];
			if (seg_hi[i] > hi) hi = seg_hi[i];
		end
		if (wanted < lo) return lo[15:0];
		if (wanted > hi) return hi[15:0];
		best = lo;
		for (int i = 0; i < seg_count; i++) begin
			st = seg_stride[i];
			if (st == 0) begin
				cand = seg_lo[i];
			end else begin
				c = wanted;
				if (c < seg_lo[i]) c = seg_lo[i];
				if (c > seg_hi[i]) c = seg_hi[i];
				n = (c - seg_lo[i] + st / 2) / st;
				cand = seg_lo[i] + n * st;
				if (cand > seg_hi[i]) cand = seg_hi[i];
			end
			delta = cand > wanted ? cand - wanted : wanted - cand;
			if (delta < min_gap) begin
				min_gap = delta;
				best = cand;
			end
		end
		return best[15:0];
	endfunction

	assign pending = answers_due.size();

	always @(posedge clk or negedge arst_n) begin
		snap_answer_t want;
		snap_answer_t got;
		if (!arst_n) begin
			seg_count = 0;
			held_first = 0;
			held_step = 0;
			held_count = 0;
			stopped = 0;
			overflow = 0;
			answers_due.delete();
			fail_count <= 0;
			snaps_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[21:0];
				snaps_seen <= snaps_seen + 1;
				if (answers_due.size() == 0) begin
					if (fail_count < 10) $display("unexpected snap beat %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = answers_due.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display({"snap mismatch: expected value %0d total %0d ovf %0d,",
								" got %0d %0d %0d"},
								want.value, want.total, want.overflowed,
								got.value, got.total, got.overflowed);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					CMD_CLEAR: begin
						seg_count = 0;
						held_count = 0;
						stopped = 0;
						overflow = 0;
					end
					CMD_LOAD: begin
						take_list_word(s_tdata[15:0]);
						if (s_tlast) begin
							flush_held_words();
							stopped = 0;
						end
					end
					CMD_SNAP: begin
						want.value = nearest_supported(s_tdata[31:16]);
						want.total = seg_count[4:0];
						want.overflowed = overflow;
						answers_due = {answers_due, want};
					end
					default: ;
				endcase
			end
		end
	end
endmodule

[tb/sv/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	int fail_count;
	int pending;
	int snaps_seen;
	int cycles = 0;
	int gap_left;
	int burst_left;
	int beats_sent;

	resolution_range_table_snap_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	rrts_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending), .snaps_seen(snaps_seen)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			case ((cycles / 300) % 3)
				0: m_tready <= 1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	function automatic logic [34:0] pack_beat(logic [1:0] cmd, logic [15:0] word,
		logic last, logic [15:0] wanted);
		return {cmd, last, wanted, word};
	endfunction

	task automatic send(logic [34:0] beat);
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
			burst_left = int'($urandom_range(1, 12));
			if (gap_left != 0) begin
				s_tvalid <= 0;
				repeat (gap_left) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1;
		s_tuser <= beat[34:33];
		s_tlast <= beat[32];
		s_tdata <= beat[31:0];
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	task automatic load(logic [15:0] word, logic last);
		send(pack_beat(CMD_LOAD, word, last, 16'($urandom)));
	endtask

	task automatic snap(logic [15:0] wanted);
		send(pack_beat(CMD_SNAP, 16'($urandom), 1'($urandom), wanted));
	endtask

	function automatic logic [15:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(1, 16'h1FFF));
			1: return 16'($urandom_range(1, 16'hDFFF));
			2: return 16'($urandom_range(16'hFF00, 16'hFFFF));
			default: return 16'($urandom_range(1, 3000));
		endcase
	endfunction

	function automatic logic [15:0] rand_step();
		return 16'hE000 | (($urandom_range(0, 5) == 0) ? 16'd0
			: 16'($urandom_range(1, 16'h1FFF)));
	endfunction

	initial begin
		int n;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 0;
		burst_left = 0;
		beats_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty table, ranges, reversed bounds, zero stride, early stop.
		snap(16'h0000);
		snap(16'hFFFF);
		load(16'd100, 1'b0);
		load(16'hE000, 1'b0);
		load(16'd50, 1'b0);
		load(16'd400, 1'b0);
		load(16'hE007, 1'b0);
		load(16'd1000, 1'b0);
		load(16'hFFFF, 1'b0);
		load(16'h0000, 1'b0);
		load(16'd9999, 1'b0);
		load(16'd5, 1'b1);
		snap(16'd0);
		snap(16'd403);
		snap(16'd404);
		snap(16'hFFFF);
		load(16'd777, 1'b0);
		load(16'hFFFF, 1'b1);
		snap(16'd700);
		send(pack_beat(CMD_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF));
		snap(16'd1);
		for (int i = 0; i < 20; i++) load(16'(2000 + i), i == 19);
		snap(16'd2005);
		send(pack_beat(CMD_CLEAR, 16'hFFFF, 1'b1, 16'hFFFF));
		snap(16'd5);

		while (beats_sent < 800) begin
			case ($urandom_range(0, 19))
				0: send(pack_beat(CMD_CLEAR, 16'($urandom), 1'($urandom), 16'($urandom)));
				1: send(pack_beat(CMD_UNUSED, 16'($urandom), 1'($urandom), 16'($urandom)));
				2, 3, 4: snap(($urandom_range(0, 3) == 0) ? 16'($urandom) : rand_value());
				5: load(16'($urandom), 1'($urandom_range(0, 1)));
				default: begin
					n = int'($urandom_range(1, 4));
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(0, 2) == 0) begin
							load(rand_value(), 1'b0);
						end else begin
							load(rand_value(), 1'b0);
							load(rand_step(), 1'b0);
							load(rand_value(), 1'b0);
						end
					end
					if ($urandom_range(0, 7) == 0) load(16'h0000, 1'b0);
					if ($urandom_range(0, 7) == 0) load(rand_value(), 1'b0);
					load(($urandom_range(0, 3) == 0) ? rand_step() : rand_value(), 1'b1);
				end
			endcase
		end
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Sent %0d beats with %0d snap answers checked.", beats_sent, snaps_seen);
		$display("Covered clears, ranged and single loads, early stops, overflow and idling.");
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
